@@ hw/rtl/bce_pkg.sv @@
// Package for the Bezier curve evaluator: types, constants, odd inverse table.
// No dependencies.
`default_nettype none
package bce_pkg;
  localparam int unsigned ONE_Q15 = 32768;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TERM,
    ST_WMUL,
    ST_BMUL,
    ST_PMUL,
    ST_DONE
  } bce_state_t;

  typedef struct packed {
    logic init;
    logic wstep;
    logic bstep;
    logic pstep;
    logic next_i;
  } bce_cmd_t;

  typedef logic [15:0][29:0] inv_tbl_t;

  // inverse mod 2^30 of odd o = 2k+1, entry k
  function automatic inv_tbl_t odd_inv_tbl();
    inv_tbl_t tbl;
    logic [63:0] o, x;
    tbl = '0;
    for (int k = 0; k < 16; k++) begin
      o = 64'(2 * k + 1);
      x = o;
      for (int r = 0; r < 5; r++) x = x * (64'd2 - o * x);
      tbl[k] = x[29:0];
    end
    return tbl;
  endfunction

  localparam inv_tbl_t ODD_INV = odd_inv_tbl();
endpackage
`default_nettype wire

@@ hw/rtl/bce_ctrl.sv @@
// Controller for the Bezier evaluator: sequences weight, binomial and point steps.
// Depends on bce_pkg.
`default_nettype none
module bce_ctrl
  import bce_pkg::*;
#(
  parameter int CW = 5
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          go,
  input  wire logic [CW-1:0] n,
  output logic               busy,
  output logic               done,
  output bce_cmd_t           cmd
);
  bce_state_t st_r, st_nxt;
  logic [CW-1:0] i_r, i_nxt, j_r, j_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
      i_r  <= '0;
      j_r  <= '0;
    end else begin
      st_r <= st_nxt;
      i_r  <= i_nxt;
      j_r  <= j_nxt;
    end
  end

  always_comb begin
    st_nxt = st_r;
    i_nxt  = i_r;
    j_nxt  = j_r;
    cmd    = '0;
    busy   = (st_r != ST_IDLE);
    done   = 1'b0;
    case (st_r)
      ST_IDLE: begin
        if (go) begin
          cmd.init = 1'b1;
          i_nxt    = '0;
          st_nxt   = ST_TERM;
        end
      end
      ST_TERM: begin
        j_nxt  = '0;
        st_nxt = (n == '0) ? ST_BMUL : ST_WMUL;
      end
      ST_WMUL: begin
        cmd.wstep = 1'b1;
        j_nxt     = j_r + 1'b1;
        if (j_r + 1'b1 == n) st_nxt = ST_BMUL;
      end
      ST_BMUL: begin
        cmd.bstep = 1'b1;
        st_nxt    = ST_PMUL;
      end
      ST_PMUL: begin
        cmd.pstep = 1'b1;
        if (i_r == n) begin
          st_nxt = ST_DONE;
        end else begin
          cmd.next_i = 1'b1;
          i_nxt      = i_r + 1'b1;
          st_nxt     = ST_TERM;
        end
      end
      ST_DONE: begin
        done   = 1'b1;
        st_nxt = ST_IDLE;
      end
      default: st_nxt = ST_IDLE;
    endcase
  end
endmodule
`default_nettype wire

@@ hw/rtl/bce_dp.sv @@
// Datapath for the Bezier evaluator: point store, weight multiplier, accumulators.
// Depends on bce_pkg.
`default_nettype none
module bce_dp
  import bce_pkg::*;
#(
  parameter int MAX_POINTS = 16,
  parameter int IW = 4,
  parameter int CW = 5
) (
  input  wire logic               clk,
  input  wire logic               wr_en,
  input  wire logic [IW-1:0]      wr_idx,
  input  wire logic signed [31:0] wr_x,
  input  wire logic signed [31:0] wr_y,
  input  wire logic signed [31:0] wr_z,
  input  wire logic [15:0]        t_in,
  input  wire logic [CW-1:0]      n,
  input  wire logic               single,
  input  wire logic               zero,
  input  wire bce_cmd_t           cmd,
  output logic signed [31:0]      res_x,
  output logic signed [31:0]      res_y,
  output logic signed [31:0]      res_z
);
  logic [95:0] mem [MAX_POINTS];
  logic [95:0] pt_r;
  logic [95:0] pt0_r;
  logic [CW-1:0] i_r, j_r;
  logic [15:0] t_r, inv_r;
  logic [15:0] p_r;
  logic [29:0] w_r;
  logic [29:0] bc_r;
  logic [34:0] num_r;
  logic [4:0] d_r;
  logic [2:0] sh;
  logic [4:0] od;
  logic [34:0] qo;
  logic [59:0] dq;
  logic signed [39:0] ax_r, ay_r, az_r;
  logic [15:0] f;
  logic [31:0] pm;
  logic [45:0] wb;
  logic signed [62:0] tx, ty, tz;
  logic [15:0] tc;

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_idx] <= {wr_x, wr_y, wr_z};
    pt_r  <= mem[i_r[IW-1:0]];
    pt0_r <= mem[0];
  end

  assign tc = (t_in > 16'(ONE_Q15)) ? 16'(ONE_Q15) : t_in;
  assign f  = (j_r < i_r) ? t_r : inv_r;
  assign pm = 32'(p_r) * 32'(f);
  assign wb = 46'(bc_r) * 46'(p_r);
  assign tx = 63'(signed'(pt_r[95:64])) * 63'(signed'({1'b0, w_r}));
  assign ty = 63'(signed'(pt_r[63:32])) * 63'(signed'({1'b0, w_r}));
  assign tz = 63'(signed'(pt_r[31:0]))  * 63'(signed'({1'b0, w_r}));

  // exact divide num_r / d_r: drop factors of two, multiply by odd inverse mod 2^30
  always_comb begin
    case (d_r) inside
      5'b????1: sh = 3'd0;
      5'b???10: sh = 3'd1;
      5'b??100: sh = 3'd2;
      5'b?1000: sh = 3'd3;
      default:  sh = 3'd4;
    endcase
    od = d_r >> sh;
    qo = num_r >> sh;
    dq = 60'(qo[29:0]) * 60'(ODD_INV[od[4:1]]);
  end

  always_ff @(posedge clk) begin
    bc_r <= dq[29:0];
    if (cmd.init) begin
      t_r   <= tc;
      inv_r <= 16'(ONE_Q15) - tc;
      i_r   <= '0;
      j_r   <= '0;
      p_r   <= 16'(ONE_Q15);
      num_r <= 35'd1;
      d_r   <= 5'd1;
      ax_r  <= '0;
      ay_r  <= '0;
      az_r  <= '0;
    end else begin
      if (cmd.wstep) begin
        p_r <= pm[30:15];
        j_r <= j_r + 1'b1;
      end
      if (cmd.bstep) w_r <= wb[29:0];
      if (cmd.pstep) begin
        ax_r <= ax_r + 40'(tx >>> 15);
        ay_r <= ay_r + 40'(ty >>> 15);
        az_r <= az_r + 40'(tz >>> 15);
      end
      if (cmd.next_i) begin
        i_r   <= i_r + 1'b1;
        j_r   <= '0;
        p_r   <= 16'(ONE_Q15);
        num_r <= 35'(bc_r) * 35'(n - i_r);
        d_r   <= 5'(i_r + 1'b1);
      end
    end
  end

  function automatic logic [31:0] sat(input logic signed [39:0] v);
    if (v > 40'sd2147483647) return 32'h7FFF_FFFF;
    if (v < -40'sd2147483648) return 32'h8000_0000;
    return v[31:0];
  endfunction

  always_comb begin
    if (zero) begin
      res_x = '0; res_y = '0; res_z = '0;
    end else if (single) begin
      res_x = pt0_r[95:64]; res_y = pt0_r[63:32]; res_z = pt0_r[31:0];
    end else begin
      res_x = sat(ax_r); res_y = sat(ay_r); res_z = sat(az_r);
    end
  end
endmodule
`default_nettype wire

@@ hw/rtl/bezier_curve_evaluator_unit.sv @@
// Top level of the Bezier curve evaluator: controller plus datapath.
// Depends on bce_pkg, bce_ctrl, bce_dp.
//   channel | ports                         | handshake
//   input   | in_kind .. in_t               | start & !busy
//   result  | out_curve_x/y/z               | out_valid, one cycle
//   config  | cfg_we, cfg_num_points        | cfg_we
// Evaluate with n+1 points: weight products use one multiplier per step of p;
// zero or one point bypasses the controller.
// rst_n is synchronous; the receiver cannot stall.
`default_nettype none
module bezier_curve_evaluator_unit
  import bce_pkg::*;
#(
  parameter int MAX_POINTS = 16
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [0:0]         in_kind,
  input  wire logic [3:0]         in_index,
  input  wire logic signed [31:0] in_point_x,
  input  wire logic signed [31:0] in_point_y,
  input  wire logic signed [31:0] in_point_z,
  input  wire logic [15:0]        in_t,
  input  wire logic               cfg_we,
  input  wire logic [4:0]         cfg_num_points,
  output logic                    out_valid,
  output logic signed [31:0]      out_curve_x,
  output logic signed [31:0]      out_curve_y,
  output logic signed [31:0]      out_curve_z
);
  localparam int IW = $clog2(MAX_POINTS);
  localparam int CW = $clog2(MAX_POINTS + 1);

  logic [4:0] np_r;
  logic [4:0] cnt;
  logic [CW-1:0] n;
  logic acc, go, cbusy, cdone, wr_en;
  logic zero_r, single_r, fast_r;
  bce_cmd_t cmd;

  always_ff @(posedge clk) begin
    if (!rst_n) np_r <= '0;
    else if (cfg_we) np_r <= cfg_num_points;
  end

  assign cnt   = (32'(np_r) > MAX_POINTS) ? 5'(MAX_POINTS) : np_r;
  assign n     = CW'(cnt - 5'd1);
  assign acc   = start && !busy;
  assign wr_en = acc && (in_kind == 1'b0) && (32'(in_index) < MAX_POINTS);
  assign go    = acc && in_kind[0] && (cnt > 5'd1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fast_r <= 1'b0;
    end else begin
      fast_r <= acc && in_kind[0] && (cnt <= 5'd1);
    end
    if (acc) begin
      zero_r   <= (cnt == 5'd0);
      single_r <= (cnt == 5'd1);
    end
  end

  assign busy      = cbusy || fast_r;
  assign out_valid = cdone || fast_r;

  bce_ctrl #(.CW(CW)) u_ctrl (
    .clk, .rst_n, .go, .n, .busy(cbusy), .done(cdone), .cmd
  );

  bce_dp #(.MAX_POINTS(MAX_POINTS), .IW(IW), .CW(CW)) u_dp (
    .clk, .wr_en, .wr_idx(IW'(in_index)), .wr_x(in_point_x), .wr_y(in_point_y),
    .wr_z(in_point_z), .t_in(in_t), .n, .single(single_r && fast_r),
    .zero(zero_r && fast_r), .cmd,
    .res_x(out_curve_x), .res_y(out_curve_y), .res_z(out_curve_z)
  );
endmodule
`default_nettype wire

@@ tb/sv/tb_bezier_curve_evaluator_unit.sv @@
// Testbench for bezier_curve_evaluator_unit (depends on bce_pkg): directed table,
// then random words; checks use an in-bench Bernstein predictor or typed values.
`timescale 1ns / 100ps
module tb_bezier_curve_evaluator_unit;
  import bce_pkg::*;

  localparam int SLOTS = 16;
  localparam bit KIND_LOAD = 1'b0;
  localparam bit KIND_EVAL = 1'b1;

  typedef struct {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
  } coord_t;

  typedef struct {
    int     np;
    bit     kind;
    int     idx;
    logic [31:0] x, y, z;
    int     t;
    bit     typed;
    coord_t want;
  } row_t;

  logic clk, rst_n, start, busy, cfg_we, out_valid;
  logic [0:0] in_kind;
  logic [3:0] in_index;
  logic signed [31:0] in_point_x, in_point_y, in_point_z;
  logic [15:0] in_t;
  logic [4:0] cfg_num_points;
  logic signed [31:0] out_curve_x, out_curve_y, out_curve_z;

  bezier_curve_evaluator_unit uut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_kind(in_kind), .in_index(in_index),
    .in_point_x(in_point_x), .in_point_y(in_point_y), .in_point_z(in_point_z),
    .in_t(in_t), .cfg_we(cfg_we), .cfg_num_points(cfg_num_points),
    .out_valid(out_valid), .out_curve_x(out_curve_x),
    .out_curve_y(out_curve_y), .out_curve_z(out_curve_z)
  );

  longint store_x[SLOTS], store_y[SLOTS], store_z[SLOTS];
  int     point_count;
  coord_t curve_q[$];
  int     errors;
  int     idle_pct;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("tb_bezier_curve_evaluator_unit NOT OK");
    $finish;
  end

  function automatic logic [31:0] clamp32(longint v);
    if (v > 64'sd2147483647) v = 64'sd2147483647;
    if (v < -64'sd2147483648) v = -64'sd2147483648;
    return v[31:0];
  endfunction

  function automatic coord_t bernstein_eval(int t_in);
    coord_t r;
    longint sx, sy, sz, w, p, binc, tt, inv;
    int cnt, n;
    sx = 0; sy = 0; sz = 0;
    cnt = (point_count > SLOTS) ? SLOTS : point_count;
    if (cnt == 1) begin
      sx = store_x[0]; sy = store_y[0]; sz = store_z[0];
    end else if (cnt > 1) begin
      tt = (t_in > ONE_Q15) ? ONE_Q15 : t_in;
      inv = ONE_Q15 - tt;
      n = cnt - 1;
      binc = 1;
      for (int i = 0; i <= n; i++) begin
        p = ONE_Q15;
        for (int j = 0; j < i; j++) p = (p * tt) >>> 15;
        for (int j = 0; j < n - i; j++) p = (p * inv) >>> 15;
        w = binc * p;
        sx += (store_x[i] * w) >>> 15;
        sy += (store_y[i] * w) >>> 15;
        sz += (store_z[i] * w) >>> 15;
        if (i < n) binc = binc * (n - i) / (i + 1);
      end
    end
    r.x = clamp32(sx); r.y = clamp32(sy); r.z = clamp32(sz);
    return r;
  endfunction

  always @(posedge clk) begin
    coord_t e;
    if (rst_n && out_valid) begin
      if (curve_q.size() == 0) begin
        $display("%t unexpected result %h %h %h", $time,
                 out_curve_x, out_curve_y, out_curve_z);
        errors++;
      end else begin
        e = curve_q.pop_front();
        if (out_curve_x !== e.x) begin
          $display("%t curve_x exp %h got %h", $time, e.x, out_curve_x); errors++;
        end
        if (out_curve_y !== e.y) begin
          $display("%t curve_y exp %h got %h", $time, e.y, out_curve_y); errors++;
        end
        if (out_curve_z !== e.z) begin
          $display("%t curve_z exp %h got %h", $time, e.z, out_curve_z); errors++;
        end
      end
    end
  end

  task automatic send_word(row_t r);
    while (($urandom % 100) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    in_kind <= r.kind;
    in_index <= r.idx[3:0];
    in_point_x <= r.x; in_point_y <= r.y; in_point_z <= r.z;
    in_t <= r.t[15:0];
    do @(posedge clk); while (busy);
    if (r.kind == KIND_LOAD) begin
      store_x[r.idx] = longint'(signed'(r.x));
      store_y[r.idx] = longint'(signed'(r.y));
      store_z[r.idx] = longint'(signed'(r.z));
    end else if (r.typed) begin
      curve_q.push_back(r.want);
    end else begin
      curve_q.push_back(bernstein_eval(r.t));
    end
  endtask

  task automatic drain_results();
    start <= 1'b0;
    @(posedge clk);
    while (curve_q.size() != 0) @(posedge clk);
  endtask

  task automatic set_point_count(int v);
    drain_results();
    repeat (340) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_num_points <= v[4:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    point_count = v;
  endtask

  row_t dir_tbl[$];

  function automatic row_t mk(int np, bit kind, int idx, logic [31:0] x, logic [31:0] y,
                              logic [31:0] z, int t);
    row_t r;
    r.np = np; r.kind = kind; r.idx = idx; r.x = x; r.y = y; r.z = z; r.t = t;
    r.typed = 1'b0;
    r.want = '{32'd0, 32'd0, 32'd0};
    return r;
  endfunction

  initial begin
    row_t r;
    int np_list[8];
    np_list = '{2, 3, 16, 31, 0, 1, 8, 17};
    errors = 0;
    point_count = 0;
    idle_pct = 0;
    start = 1'b0; in_kind = '0; in_index = '0;
    in_point_x = '0; in_point_y = '0; in_point_z = '0; in_t = '0;
    cfg_we = 1'b0; cfg_num_points = '0;
    rst_n = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    dir_tbl.push_back(mk(0, KIND_LOAD, 0, 32'h7fffffff, 32'h80000000, 32'h0, 0));
    dir_tbl.push_back(mk(0, KIND_LOAD, 15, 32'h80000000, 32'h7fffffff, 32'hffffffff, 0));
    for (int k = 1; k < 15; k++)
      dir_tbl.push_back(mk(0, KIND_LOAD, k, $urandom, $urandom, $urandom, 0));
    r = mk(0, KIND_EVAL, 0, 0, 0, 0, 16384); r.typed = 1'b1;
    dir_tbl.push_back(r);
    r = mk(1, KIND_EVAL, 0, 0, 0, 0, 65535); r.typed = 1'b1;
    r.want = '{32'h7fffffff, 32'h80000000, 32'h0};
    dir_tbl.push_back(r);
    dir_tbl.push_back(mk(2, KIND_EVAL, 0, 0, 0, 0, 0));
    dir_tbl.push_back(mk(2, KIND_EVAL, 0, 0, 0, 0, 32768));
    dir_tbl.push_back(mk(2, KIND_EVAL, 0, 0, 0, 0, 65535));
    dir_tbl.push_back(mk(16, KIND_EVAL, 0, 0, 0, 0, 1));
    dir_tbl.push_back(mk(16, KIND_EVAL, 0, 0, 0, 0, 32767));
    dir_tbl.push_back(mk(31, KIND_EVAL, 0, 0, 0, 0, 16384));

    foreach (dir_tbl[k]) begin
      if (dir_tbl[k].np != point_count) set_point_count(dir_tbl[k].np);
      send_word(dir_tbl[k]);
    end

    for (int ph = 0; ph < 8; ph++) begin
      set_point_count(np_list[ph]);
      case (ph % 4)
        0: idle_pct = 0;
        1: idle_pct = 61;
        2: idle_pct = 0;
        default: idle_pct = 14;
      endcase
      for (int k = 0; k < 55; k++) begin
        if (ph == 1 && k == 20) drain_results();
        r = mk(0, ($urandom % 10) < 6 ? KIND_EVAL : KIND_LOAD, $urandom_range(0, 15),
               $urandom, $urandom, $urandom,
               ($urandom % 8 == 0) ? $urandom_range(0, 65535) : $urandom_range(0, 32768));
        send_word(r);
      end
    end

    drain_results();
    repeat (400) @(posedge clk);
    if (errors == 0) begin
      $display("tb_bezier_curve_evaluator_unit OK");
    end else begin
      $display("tb_bezier_curve_evaluator_unit NOT OK");
    end
    $finish;
  end
endmodule

@@ files.f @@
hw/rtl/bce_pkg.sv
hw/rtl/bce_ctrl.sv
hw/rtl/bce_dp.sv
hw/rtl/bezier_curve_evaluator_unit.sv
tb/sv/tb_bezier_curve_evaluator_unit.sv
